### src/drse_pkg.sv
`timescale 1ns / 1ps
// drse_pkg: shared types and codes for the disjoint range set engine
// no dependencies; used by the cells, the top level and the testbench
package drse_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_FIT      = 2'd3;

    typedef struct packed {
        logic [3:0]  space;
        logic [63:0] first;
        logic [63:0] last;
    } t_entry;

    typedef struct packed {
        logic [3:0]  space;
        logic [63:0] first;
        logic [63:0] last;
        logic [63:0] mf;
        logic [63:0] ml;
        logic [63:0] lp1;
        logic [63:0] fm1;
    } t_key;

    typedef struct packed {
        logic eval;
        logic ins_merge;
        logic ins_new;
        logic rem;
        logic compact;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic lt;
        logic hold;
        logic cutl;
        logic cutr;
        logic adj;
    } t_flags;

endpackage

### src/drse_if.sv
`timescale 1ns / 1ps
// drse request and response channel interfaces
// valid/ready handshake; no package dependency
interface drse_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  space_id;
    logic [63:0] first_offset;
    logic [63:0] last_offset;
    logic [30:0] span_size;
    logic [63:0] max_size;
    logic        addr_invalid;

    modport source (output valid, opcode, space_id, first_offset, last_offset, span_size,
                    max_size, addr_invalid, input ready);
    modport sink (input valid, opcode, space_id, first_offset, last_offset, span_size,
                  max_size, addr_invalid, output ready);
endinterface

interface drse_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        covered;
    logic        holder_found;
    logic [63:0] holder_first;
    logic [63:0] holder_last;
    logic [63:0] fit_bytes;
    logic [5:0]  entry_total;

    modport source (output valid, status, covered, holder_found, holder_first, holder_last,
                    fit_bytes, entry_total, input ready);
    modport sink (input valid, status, covered, holder_found, holder_first, holder_last,
                  fit_bytes, entry_total, output ready);
endinterface

### src/drse_cell.sv
`timescale 1ns / 1ps
// drse_cell: one table slot with its local compares and neighbor shifts
// depends on drse_pkg
module drse_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  drse_pkg::t_cmd   i_cmd,
    input  drse_pkg::t_key   i_key,
    input  logic [CW-1:0]    i_count,
    input  drse_pkg::t_entry i_left,
    input  drse_pkg::t_flags i_left_flags,
    input  logic             i_left_sh,
    input  logic             i_left_dd,
    input  drse_pkg::t_entry i_right,
    input  logic             i_right_dead,
    output drse_pkg::t_entry o_entry,
    output drse_pkg::t_flags o_flags,
    output logic             o_dead,
    output logic             o_sh,
    output logic             o_dd
);

    localparam logic [CW-1:0] MY = CW'(IDX);

    drse_pkg::t_entry r_e, n_e;
    drse_pkg::t_flags r_f, n_f;
    logic             r_dead, n_dead;
    logic             w_v, w_same, w_split, w_left_split;

    assign w_v          = MY < i_count;
    assign w_same       = r_e.space == i_key.space;
    assign w_split      = r_f.hit & r_f.cutl & r_f.cutr;
    assign w_left_split = i_left_flags.hit & i_left_flags.cutl & i_left_flags.cutr;

    always_comb begin
        n_e    = r_e;
        n_f    = r_f;
        n_dead = r_dead;
        if (i_cmd.eval) begin
            n_f.hit  = w_v & w_same & (r_e.last >= i_key.first) & (r_e.first <= i_key.last);
            n_f.lt   = w_v & ~n_f.hit & ((r_e.space < i_key.space) |
                       (w_same & (r_e.first < i_key.first)));
            n_f.hold = w_v & w_same & (r_e.first <= i_key.first) & (r_e.last >= i_key.first);
            n_f.cutl = r_e.first < i_key.first;
            n_f.cutr = r_e.last > i_key.last;
            n_f.adj  = (IDX != 0) & w_v & (r_e.space == i_left.space) &
                       (r_e.first == i_left.last + 64'd1);
        end
        if (i_cmd.ins_merge) begin
            n_dead = 1'b0;
            if (r_f.hit) begin
                if (!i_left_flags.hit) begin
                    n_e = '{space: i_key.space, first: i_key.mf, last: i_key.ml};
                end else begin
                    n_dead = 1'b1;
                end
            end
        end
        if (i_cmd.ins_new) begin
            n_dead = 1'b0;
            if (i_left_flags.lt && !r_f.lt) begin
                n_e = '{space: i_key.space, first: i_key.first, last: i_key.last};
            end else if (!i_left_flags.lt) begin
                n_e = i_left;
            end
        end
        if (i_cmd.rem) begin
            n_dead = 1'b0;
            if (i_left_sh) begin
                if (w_left_split) begin
                    n_e = '{space: i_key.space, first: i_key.lp1, last: i_left.last};
                end else begin
                    n_e = i_left;
                end
            end else if (r_f.hit) begin
                if (r_f.cutl) begin
                    n_e.last = i_key.fm1;
                end else if (r_f.cutr) begin
                    n_e.first = i_key.lp1;
                end else begin
                    n_dead = 1'b1;
                end
            end
        end
        if (i_cmd.compact && (i_left_dd || r_dead)) begin
            n_e    = i_right;
            n_dead = i_right_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            r_dead <= n_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
        r_f <= n_f;
    end

    assign o_entry = r_e;
    assign o_flags = r_f;
    assign o_dead  = r_dead;
    assign o_sh    = i_left_sh | w_split;
    assign o_dd    = i_left_dd | r_dead;

endmodule

### src/disjoint_range_set_engine.sv
`timescale 1ns / 1ps
// disjoint_range_set_engine: sorted range table kept in a chain of drse_cell slots
// insert and remove evaluate, select, update, then compact one dropped range per step;
// contains evaluates, selects and checks; longest fit also walks one range per cycle
// throughput: one transaction at a time; the next is taken the cycle after the result loads
// sync active-low reset empties the table (count 0) and drops any pending result
module disjoint_range_set_engine #(
    parameter int CAPACITY   = 32,
    parameter int SPACE_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drse_req_if.sink    i_req,
    drse_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [3:0]    SMASK = 4'((1 << SPACE_BITS) - 1);
    localparam logic [CW-1:0] CAPC  = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_WALK = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_oval, n_oval;
    drse_pkg::t_key   r_key, n_key;
    logic [1:0]       r_op, n_op;
    logic [30:0]      r_size, n_size;
    logic [63:0]      r_max, n_max;
    logic             r_inv, n_inv;
    logic             r_any_hit, n_any_hit, r_any_split, n_any_split;
    logic             r_status, n_status, r_covered, n_covered, r_found, n_found;
    logic [63:0]      r_hf, n_hf, r_hl, n_hl, r_fit, n_fit;
    logic [IW-1:0]    r_ptr, n_ptr;
    logic             r_o_status, n_o_status, r_o_covered, n_o_covered;
    logic             r_o_found, n_o_found;
    logic [63:0]      r_o_hf, n_o_hf, r_o_hl, n_o_hl, r_o_fit, n_o_fit;
    logic [5:0]       r_o_total, n_o_total;

    drse_pkg::t_cmd   w_cmd;
    drse_pkg::t_entry w_ent [CAPACITY];
    drse_pkg::t_flags w_flg [CAPACITY];
    logic             w_dead [CAPACITY];
    logic             w_sh [CAPACITY];
    logic             w_dd [CAPACITY];

    logic             w_any_hit, w_any_split, w_any_hold, w_any_dead, w_full;
    logic [63:0]      w_mfsel, w_mlsel, w_hf, w_hl, w_fit, w_last_sel;
    logic [IW-1:0]    w_hidx;
    logic [CW-1:0]    w_nxt;
    logic             w_cont;
    logic [30:0]      w_span;
    logic [64:0]      w_end;
    logic [CW+5:0]    w_total_ext;

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        drse_pkg::t_entry w_l;
        drse_pkg::t_flags w_lf;
        drse_pkg::t_entry w_r;
        logic             w_lsh, w_ldd, w_rdead;
        if (j == 0) begin : g_first
            assign w_l   = '0;
            assign w_lf  = '{hit: 1'b0, lt: 1'b1, hold: 1'b0, cutl: 1'b0, cutr: 1'b0, adj: 1'b0};
            assign w_lsh = 1'b0;
            assign w_ldd = 1'b0;
        end else begin : g_mid
            assign w_l   = w_ent[j-1];
            assign w_lf  = w_flg[j-1];
            assign w_lsh = w_sh[j-1];
            assign w_ldd = w_dd[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign w_r     = '0;
            assign w_rdead = 1'b0;
        end else begin : g_next
            assign w_r     = w_ent[j+1];
            assign w_rdead = w_dead[j+1];
        end
        drse_cell #(.IDX(j), .CW(CW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_key        (r_key),
            .i_count      (r_count),
            .i_left       (w_l),
            .i_left_flags (w_lf),
            .i_left_sh    (w_lsh),
            .i_left_dd    (w_ldd),
            .i_right      (w_r),
            .i_right_dead (w_rdead),
            .o_entry      (w_ent[j]),
            .o_flags      (w_flg[j]),
            .o_dead       (w_dead[j]),
            .o_sh         (w_sh[j]),
            .o_dd         (w_dd[j])
        );
    end

    // reductions over the registered cell flags
    always_comb begin
        w_any_hit   = 1'b0;
        w_any_split = 1'b0;
        w_any_hold  = 1'b0;
        w_any_dead  = 1'b0;
        w_mfsel     = '0;
        w_mlsel     = '0;
        w_hf        = '0;
        w_hl        = '0;
        w_hidx      = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_any_hit   = w_any_hit | w_flg[j].hit;
            w_any_split = w_any_split | (w_flg[j].hit & w_flg[j].cutl & w_flg[j].cutr);
            w_any_hold  = w_any_hold | w_flg[j].hold;
            w_any_dead  = w_any_dead | w_dead[j];
            if (w_flg[j].hit && (j == 0 || !w_flg[(j == 0) ? 0 : j-1].hit)) begin
                w_mfsel = w_mfsel | w_ent[j].first;
            end
            if (w_flg[j].hit && (j == CAPACITY - 1 ||
                                 !w_flg[(j == CAPACITY - 1) ? j : j+1].hit)) begin
                w_mlsel = w_mlsel | w_ent[j].last;
            end
            if (w_flg[j].hold) begin
                w_hf   = w_hf | w_ent[j].first;
                w_hl   = w_hl | w_ent[j].last;
                w_hidx = w_hidx | IW'(j);
            end
        end
    end

    assign w_full     = (r_count == CAPC) &
                        ((r_op == drse_pkg::OP_INSERT) ? ~r_any_hit : r_any_split);
    assign w_last_sel = w_ent[r_ptr].last;
    assign w_fit      = w_last_sel + 64'd1 - r_key.first;
    assign w_nxt      = CW'(r_ptr) + CW'(1);
    assign w_cont     = (w_nxt < r_count) && w_flg[w_nxt[IW-1:0]].adj;
    assign w_span     = (r_size == 31'd0) ? 31'd1 : r_size;
    assign w_end      = {1'b0, r_key.first} + 65'(w_span - 31'd1);
    assign w_total_ext = {6'd0, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_oval      = r_oval;
        n_key       = r_key;
        n_op        = r_op;
        n_size      = r_size;
        n_max       = r_max;
        n_inv       = r_inv;
        n_any_hit   = r_any_hit;
        n_any_split = r_any_split;
        n_status    = r_status;
        n_covered   = r_covered;
        n_found     = r_found;
        n_hf        = r_hf;
        n_hl        = r_hl;
        n_fit       = r_fit;
        n_ptr       = r_ptr;
        n_o_status  = r_o_status;
        n_o_covered = r_o_covered;
        n_o_found   = r_o_found;
        n_o_hf      = r_o_hf;
        n_o_hl      = r_o_hl;
        n_o_fit     = r_o_fit;
        n_o_total   = r_o_total;
        w_cmd       = '0;
        if (r_oval && o_rsp.ready) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key.space = i_req.space_id & SMASK;
                    n_key.first = i_req.first_offset;
                    n_key.last  = i_req.last_offset;
                    n_key.lp1   = i_req.last_offset + 64'd1;
                    n_key.fm1   = i_req.first_offset - 64'd1;
                    n_op        = i_req.opcode;
                    n_size      = i_req.span_size;
                    n_max       = i_req.max_size;
                    n_inv       = i_req.addr_invalid;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                w_cmd.eval = 1'b1;
                n_state    = S_SEL;
            end
            S_SEL: begin
                n_any_hit   = w_any_hit;
                n_any_split = w_any_split;
                n_key.mf    = (w_any_hit && w_mfsel < r_key.first) ? w_mfsel : r_key.first;
                n_key.ml    = (w_any_hit && w_mlsel > r_key.last) ? w_mlsel : r_key.last;
                n_status    = 1'b0;
                n_covered   = 1'b0;
                n_found     = 1'b0;
                n_hf        = '0;
                n_hl        = '0;
                n_fit       = '0;
                n_ptr       = w_hidx;
                if (r_op == drse_pkg::OP_INSERT || r_op == drse_pkg::OP_REMOVE) begin
                    n_state = (r_key.last < r_key.first) ? S_RESP : S_UPD;
                end else if (r_inv) begin
                    n_covered = (r_op == drse_pkg::OP_CONTAINS);
                    n_state   = S_RESP;
                end else if (!w_any_hold) begin
                    n_state = S_RESP;
                end else begin
                    n_found = 1'b1;
                    n_hf    = w_hf;
                    n_hl    = w_hl;
                    n_state = (r_op == drse_pkg::OP_CONTAINS) ? S_CHK : S_WALK;
                end
            end
            S_UPD: begin
                if (w_full) begin
                    n_status = 1'b1;
                    n_state  = S_RESP;
                end else begin
                    if (r_op == drse_pkg::OP_INSERT) begin
                        w_cmd.ins_merge = r_any_hit;
                        w_cmd.ins_new   = ~r_any_hit;
                        if (!r_any_hit) begin
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        w_cmd.rem = 1'b1;
                        if (r_any_split) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_any_dead) begin
                    w_cmd.compact = 1'b1;
                    n_count       = r_count - CW'(1);
                end else begin
                    n_state = S_RESP;
                end
            end
            S_CHK: begin
                n_covered = ~w_end[64] & (w_end[63:0] <= r_hl);
                n_state   = S_RESP;
            end
            S_WALK: begin
                if (w_fit >= r_max || !w_cont) begin
                    n_fit   = w_fit;
                    n_state = S_RESP;
                end else begin
                    n_ptr = w_nxt[IW-1:0];
                end
            end
            S_RESP: begin
                if (!r_oval || o_rsp.ready) begin
                    n_oval      = 1'b1;
                    n_o_status  = r_status;
                    n_o_covered = r_covered;
                    n_o_found   = r_found;
                    n_o_hf      = r_hf;
                    n_o_hl      = r_hl;
                    n_o_fit     = r_fit;
                    n_o_total   = w_total_ext[5:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_op        <= n_op;
        r_size      <= n_size;
        r_max       <= n_max;
        r_inv       <= n_inv;
        r_any_hit   <= n_any_hit;
        r_any_split <= n_any_split;
        r_status    <= n_status;
        r_covered   <= n_covered;
        r_found     <= n_found;
        r_hf        <= n_hf;
        r_hl        <= n_hl;
        r_fit       <= n_fit;
        r_ptr       <= n_ptr;
        r_o_status  <= n_o_status;
        r_o_covered <= n_o_covered;
        r_o_found   <= n_o_found;
        r_o_hf      <= n_o_hf;
        r_o_hl      <= n_o_hl;
        r_o_fit     <= n_o_fit;
        r_o_total   <= n_o_total;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_oval;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.covered      = r_o_covered;
    assign o_rsp.holder_found = r_o_found;
    assign o_rsp.holder_first = r_o_hf;
    assign o_rsp.holder_last  = r_o_hl;
    assign o_rsp.fit_bytes    = r_o_fit;
    assign o_rsp.entry_total  = r_o_total;

endmodule

### src/drse_checker.sv
`timescale 1ns / 1ps
// drse_checker: port-level assertions for disjoint_range_set_engine
// bound to the top level; no package dependency
module drse_checker #(
    parameter int CAPACITY = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_status,
    input logic        i_found,
    input logic [63:0] i_hf,
    input logic [63:0] i_hl,
    input logic [5:0]  i_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction taken while busy");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CAPACITY > 63) || (int'(i_total) <= CAPACITY))
        else $error("entry total above capacity");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_total == 6'(CAPACITY))
        else $error("full status with room left");

    a_holder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_hf <= i_hl)
        else $error("holder range reversed");

endmodule

bind disjoint_range_set_engine drse_checker #(.CAPACITY(CAPACITY)) u_drse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found     (o_rsp.holder_found),
    .i_hf        (o_rsp.holder_first),
    .i_hl        (o_rsp.holder_last),
    .i_total     (o_rsp.entry_total)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for disjoint_range_set_engine: drives range transactions, keeps its own range table
// and checks every response field in order; depends on drse_pkg, drse_if and the engine rtl
module testbench;

    localparam int TABLE_SLOTS = 32;
    localparam int STALL_LIMIT = 4000;
    localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        status;
        logic        covered;
        logic        holder_found;
        logic [63:0] holder_first;
        logic [63:0] holder_last;
        logic [63:0] fit_bytes;
        logic [5:0]  entry_total;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    drse_req_if req ();
    drse_rsp_if rsp ();

    disjoint_range_set_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #6 i_clk = ~i_clk;

    drse_pkg::t_entry range_tab [TABLE_SLOTS];
    int               range_cnt = 0;
    t_answer          answer_q [$];
    int               errors = 0;
    int               tx_idle = 0;
    int               rx_idle = 0;
    int               quiet_cycles = 0;

    initial begin
        req.valid        = 1'b0;
        req.opcode       = drse_pkg::OP_INSERT;
        req.space_id     = '0;
        req.first_offset = '0;
        req.last_offset  = '0;
        req.span_size    = '0;
        req.max_size     = '0;
        req.addr_invalid = 1'b0;
        rsp.ready        = 1'b0;
    end

    function automatic bit key_below(logic [3:0] sa, logic [63:0] fa, logic [3:0] sb,
                                     logic [63:0] fb);
        return sa < sb || (sa == sb && fa < fb);
    endfunction

    function automatic bit overlaps(drse_pkg::t_entry e, logic [3:0] s, logic [63:0] f,
                                    logic [63:0] l);
        return e.space == s && e.last >= f && e.first <= l;
    endfunction

    function automatic void store_table(drse_pkg::t_entry nq [$], output logic rejected);
        rejected = nq.size() > TABLE_SLOTS;
        if (!rejected) begin
            foreach (nq[i]) range_tab[i] = nq[i];
            range_cnt = nq.size();
        end
    endfunction

    function automatic logic merge_range(logic [3:0] s, logic [63:0] f, logic [63:0] l);
        drse_pkg::t_entry nq [$];
        logic [63:0] mf, ml;
        bit placed;
        logic rej;
        mf = f;
        ml = l;
        placed = 0;
        for (int i = 0; i < range_cnt; i++)
            if (overlaps(range_tab[i], s, f, l)) begin
                if (range_tab[i].first < mf) mf = range_tab[i].first;
                if (range_tab[i].last > ml) ml = range_tab[i].last;
            end
        for (int i = 0; i < range_cnt; i++) begin
            if (overlaps(range_tab[i], s, f, l)) continue;
            if (!placed && key_below(s, mf, range_tab[i].space, range_tab[i].first)) begin
                nq.push_back('{s, mf, ml});
                placed = 1;
            end
            nq.push_back(range_tab[i]);
        end
        if (!placed) nq.push_back('{s, mf, ml});
        store_table(nq, rej);
        return rej;
    endfunction

    function automatic logic cut_range(logic [3:0] s, logic [63:0] f, logic [63:0] l);
        drse_pkg::t_entry nq [$];
        logic rej;
        for (int i = 0; i < range_cnt; i++) begin
            if (overlaps(range_tab[i], s, f, l)) begin
                if (range_tab[i].first < f) nq.push_back('{s, range_tab[i].first, f - 64'd1});
                if (range_tab[i].last > l) nq.push_back('{s, l + 64'd1, range_tab[i].last});
            end else begin
                nq.push_back(range_tab[i]);
            end
        end
        store_table(nq, rej);
        return rej;
    endfunction

    function automatic t_answer predict_answer(logic [1:0] op, logic [3:0] s, logic [63:0] f,
                                               logic [63:0] l, logic [30:0] sz,
                                               logic [63:0] mx, logic inv);
        t_answer a;
        int h;
        logic [63:0] span, span_end, off;
        a = '0;
        if (op == drse_pkg::OP_INSERT || op == drse_pkg::OP_REMOVE) begin
            if (l >= f) a.status = (op == drse_pkg::OP_INSERT) ? merge_range(s, f, l)
                                                                : cut_range(s, f, l);
        end else if (inv) begin
            a.covered = (op == drse_pkg::OP_CONTAINS);
        end else begin
            h = -1;
            for (int i = 0; i < range_cnt; i++)
                if (!key_below(s, f, range_tab[i].space, range_tab[i].first)) h = i;
            if (h >= 0 && (range_tab[h].space != s || range_tab[h].last < f)) h = -1;
            if (h >= 0) begin
                a.holder_found = 1'b1;
                a.holder_first = range_tab[h].first;
                a.holder_last  = range_tab[h].last;
                if (op == drse_pkg::OP_CONTAINS) begin
                    span = (sz == 0) ? 64'd1 : 64'(sz);
                    span_end = f + (span - 64'd1);
                    a.covered = span_end >= f && span_end <= range_tab[h].last;
                end else begin
                    off = f;
                    for (int i = h; i < range_cnt; i++) begin
                        if (range_tab[i].space != s || range_tab[i].first > off) break;
                        a.fit_bytes += range_tab[i].last + 64'd1 - off;
                        off = range_tab[i].last + 64'd1;
                        if (a.fit_bytes >= mx) break;
                    end
                end
            end
        end
        a.entry_total = 6'(range_cnt);
        return a;
    endfunction

    task automatic send_item(logic [1:0] op, logic [3:0] s, logic [63:0] f, logic [63:0] l,
                             logic [30:0] sz, logic [63:0] mx, logic inv);
        int gap;
        req.valid        <= 1'b1;
        req.opcode       <= op;
        req.space_id     <= s;
        req.first_offset <= f;
        req.last_offset  <= l;
        req.span_size    <= sz;
        req.max_size     <= mx;
        req.addr_invalid <= inv;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        answer_q.push_back(predict_answer(op, s, f, l, sz, mx, inv));
        if ($urandom_range(99) < tx_idle) begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_answers();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(rsp.entry_total), '0);
            end else begin
                w = answer_q.pop_front();
                if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
                if (rsp.covered !== w.covered) report_mismatch("covered", rsp.covered, w.covered);
                if (rsp.holder_found !== w.holder_found)
                    report_mismatch("holder_found", rsp.holder_found, w.holder_found);
                if (rsp.holder_first !== w.holder_first)
                    report_mismatch("holder_first", rsp.holder_first, w.holder_first);
                if (rsp.holder_last !== w.holder_last)
                    report_mismatch("holder_last", rsp.holder_last, w.holder_last);
                if (rsp.fit_bytes !== w.fit_bytes)
                    report_mismatch("fit_bytes", rsp.fit_bytes, w.fit_bytes);
                if (rsp.entry_total !== w.entry_total)
                    report_mismatch("entry_total", rsp.entry_total, w.entry_total);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(drse_pkg::OP_CONTAINS, 4'd0, 64'd0, 64'd0, 31'd1, 64'd0, 1'b0);
        send_item(drse_pkg::OP_FIT, 4'd0, 64'd0, 64'd0, 31'd0, TOP, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd15, 64'd0, TOP, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_CONTAINS, 4'd15, TOP - 64'd3, 64'd0, 31'd8, 64'd0, 1'b0);
        send_item(drse_pkg::OP_CONTAINS, 4'd15, TOP, 64'd0, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd15, 64'd100, 64'd200, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd15, 64'd0, TOP, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd2, 64'd50, 64'd10, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd2, 64'd50, 64'd10, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd3, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 31'd0, 64'd0,
                  1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd3, 64'h8000_0000_0000_0000, TOP, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_FIT, 4'd3, 64'd0, 64'd0, 31'd0, TOP, 1'b0);
        send_item(drse_pkg::OP_FIT, 4'd3, 64'd16, 64'd0, 31'd0, 64'd5, 1'b0);
        send_item(drse_pkg::OP_CONTAINS, 4'd3, 64'h7FFF_FFFF_FFFF_FFF0, 64'd0, 31'h7FFF_FFFF,
                  64'd0, 1'b0);
        send_item(drse_pkg::OP_CONTAINS, 4'd3, 64'd0, 64'd0, 31'd5, 64'd0, 1'b1);
        send_item(drse_pkg::OP_FIT, 4'd3, 64'd0, 64'd0, 31'd5, TOP, 1'b1);
        send_item(drse_pkg::OP_INSERT, 4'd1, 64'd10, 64'd20, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd1, 64'd21, 64'd30, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd1, 64'd15, 64'd25, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_FIT, 4'd1, 64'd12, 64'd0, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_CONTAINS, 4'd1, 64'd9, 64'd0, 31'd2, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd1, 64'd12, 64'd14, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd3, 64'd0, TOP, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd1, 64'd0, TOP, 31'd0, 64'd0, 1'b0);
        drain_answers();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_item(drse_pkg::OP_INSERT, 4'd5, 64'(i * 10), 64'(i * 10 + 5), 31'd0, 64'd0,
                      1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd6, 64'd0, 64'd1, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd5, 64'd2, 64'd3, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_INSERT, 4'd5, 64'd0, 64'd25, 31'd0, 64'd0, 1'b0);
        send_item(drse_pkg::OP_FIT, 4'd5, 64'd0, 64'd0, 31'd0, TOP, 1'b0);
        send_item(drse_pkg::OP_REMOVE, 4'd5, 64'd0, TOP, 31'd0, 64'd0, 1'b0);
        drain_answers();
    endtask

    task automatic test_random(int n);
        logic [1:0]  op;
        logic [3:0]  s;
        logic [63:0] base, f, l, mx;
        logic [30:0] sz;
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(99);
            if (mode < 70) base = 64'd0;
            else if (mode < 85) base = TOP - 64'd255;
            else base = {$urandom, $urandom};
            s = 4'($urandom_range(0, 2));
            if ($urandom_range(9) == 0) s = 4'($urandom);
            f = base + 64'($urandom_range(0, 255));
            l = f + 64'($urandom_range(0, 40));
            if ($urandom_range(19) == 0) l = {$urandom, $urandom};
            sz = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 48));
            mx = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 200));
            case ($urandom_range(9))
                0, 1, 2: op = drse_pkg::OP_INSERT;
                3, 4:    op = drse_pkg::OP_REMOVE;
                5, 6:    op = drse_pkg::OP_CONTAINS;
                default: op = drse_pkg::OP_FIT;
            endcase
            if (range_cnt > 28 && $urandom_range(3) == 0) begin
                op = drse_pkg::OP_REMOVE;
                l = f + 64'($urandom_range(0, 255));
            end
            send_item(op, s, f, l, sz, mx, $urandom_range(15) == 0);
            if ($urandom_range(199) == 0) drain_answers();
        end
        drain_answers();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle = 27;
        rx_idle = 48;
        test_directed();
        test_table_full();
        test_random(660);
        tx_idle = 48;
        rx_idle = 27;
        test_random(660);
        tx_idle = 0;
        rx_idle = 0;
        test_random(660);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### disjoint_range_set_engine.f
src/drse_pkg.sv
src/drse_if.sv
src/drse_cell.sv
src/disjoint_range_set_engine.sv
src/drse_checker.sv
tb/testbench.sv
